// ===== hw/rtl/dft_pkg.sv =====
// Shared types, character codes and byte classifiers for the data file tokenizer.
package dft_pkg;

  // Record kinds on the result channel
  typedef enum logic [3:0] {
    KIND_IDENT      = 4'd0,
    KIND_STRING     = 4'd1,
    KIND_INTEGER    = 4'd2,
    KIND_OPEN       = 4'd3,
    KIND_CLOSE      = 4'd4,
    KIND_SEMICOLON  = 4'd5,
    KIND_BADCHAR    = 4'd6,
    KIND_BADHEX     = 4'd7,
    KIND_UNEXPECTED = 4'd8,
    KIND_END        = 4'd9
  } kind_t;

  // Lexer state, one-hot
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_WORD  = 3'b010,
    MODE_QUOTE = 3'b100
  } lex_mode_t;

  // What has been seen so far in the current word
  typedef struct packed {
    logic hbad;   // non-hex byte after 0x
    logic hdig;   // at least one hex digit
    logic hneg;   // '-' right after 0x
    logic hex;    // word opened with 0x / 0X
    logic dbad;   // byte that cannot be part of a decimal number
    logic ddig;   // at least one decimal digit
    logic neg;    // leading '-'
  } word_flags_t;

  localparam int ERR_W = 16;
  localparam logic [ERR_W-1:0] ERR_MAX = '1;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_X   = 8'h78;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  function automatic logic is_dec_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_word_byte(logic [7:0] c);
    return is_dec_digit(c) || ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_Z)) || (c == CH_MINUS) || (c == CH_UNDER);
  endfunction

  // {valid, value}; letters a-f and A-F have low nibble 1..6
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (is_dec_digit(c)) begin
      r = {1'b1, c[3:0]};
    end else if (((c >= CH_LO_A) && (c <= CH_LO_F)) || ((c >= CH_UP_A) && (c <= CH_UP_F))) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

  function automatic logic [ERR_W-1:0] sat_err(logic [ERR_W-1:0] e);
    return (e != ERR_MAX) ? ERR_W'(e + 1'b1) : e;
  endfunction

endpackage

// ===== hw/rtl/data_file_tokenizer_top.sv =====
// Data file tokenizer: lexer state, record builder and result queue.
//
// Usage: one text byte (or an end-of-input marker) per transfer on the in_
// channel; token records leave on the out_ channel, one per transfer. Each
// input item gives zero, one or two records; out_last_of_run marks the last
// record of an item. Carriage returns give nothing; an end-of-input item
// flushes any open token, emits an end record carrying the error count and
// returns the lexer to its reset state for the next file.
// Queue: the records of an item are written to a four-entry result queue
// at the edge that takes the item and can leave in the next cycle.
// Throughput: one input item per cycle while in_stall is low, bounded by
// the single result port at one record per cycle; an item that closes a
// token and has its own record (brace after word, end marker) yields two.
// Stall: in_stall rises when fewer than two queue entries are free, so a
// held out_stall fills the queue and then holds the input side; the head
// record does not change while out_stall is high.
// Reset (rst_n low, synchronous): line counter to one, column, error count
// and lexer mode cleared, result queue emptied.
module data_file_tokenizer_top #(
  parameter int MAX_LINE_LENGTH = 4096,
  parameter int LINE_COUNT_BITS = 20,
  parameter int VALUE_BITS      = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_text_byte,
  input  logic                                in_end_of_input,
  output logic                                out_valid,
  input  logic                                out_stall,
  output dft_pkg::kind_t                      out_kind,
  output logic signed [VALUE_BITS-1:0]        out_int_value,
  output logic [LINE_COUNT_BITS-1:0]          out_line_number,
  output logic [$clog2(MAX_LINE_LENGTH)-1:0]  out_start_column,
  output logic [$clog2(MAX_LINE_LENGTH)-1:0]  out_text_length,
  output logic [dft_pkg::ERR_W-1:0]           out_error_count,
  output logic                                out_last_of_run
);
  import dft_pkg::*;

  localparam int COL_W = $clog2(MAX_LINE_LENGTH);
  localparam int ACC_W = VALUE_BITS + 5;
  localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_LINE_LENGTH - 1);
  localparam logic [LINE_COUNT_BITS-1:0] LINE_MAX = '1;
  localparam logic [VALUE_BITS-1:0] MAG_LIM = VALUE_BITS'(1) << (VALUE_BITS - 1);
  localparam int Q_DEPTH = 4;
  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  typedef struct packed {
    kind_t                      kind;
    logic [VALUE_BITS-1:0]      value;
    logic [LINE_COUNT_BITS-1:0] line;
    logic [COL_W-1:0]           col;
    logic [COL_W-1:0]           len;
    logic [ERR_W-1:0]           errs;
    logic                       last;
  } rec_t;

  typedef struct packed {
    word_flags_t           flags;
    logic [VALUE_BITS-1:0] dec;
    logic [VALUE_BITS-1:0] hex;
    logic [COL_W-1:0]      len;
  } word_st_t;

  // ---------------------------------------------------------------- helpers
  function automatic logic [COL_W-1:0] sat_col(logic [COL_W-1:0] v);
    return (v < COL_MAX) ? COL_W'(v + 1'b1) : COL_MAX;
  endfunction

  // mag*10+d, saturating at the magnitude limit
  function automatic logic [VALUE_BITS-1:0] acc10(logic [VALUE_BITS-1:0] mag, logic [3:0] d);
    logic [ACC_W-1:0] ext;
    logic [ACC_W-1:0] sum;
    ext = ACC_W'(mag);
    sum = (ext << 3) + (ext << 1) + ACC_W'(d);
    return (sum > ACC_W'(MAG_LIM)) ? MAG_LIM : sum[VALUE_BITS-1:0];
  endfunction

  // mag*16+d, saturating at the magnitude limit
  function automatic logic [VALUE_BITS-1:0] acc16(logic [VALUE_BITS-1:0] mag, logic [3:0] d);
    logic [ACC_W-1:0] ext;
    logic [ACC_W-1:0] sum;
    ext = ACC_W'(mag);
    sum = (ext << 4) + ACC_W'(d);
    return (sum > ACC_W'(MAG_LIM)) ? MAG_LIM : sum[VALUE_BITS-1:0];
  endfunction

  function automatic logic [VALUE_BITS-1:0] signed_val(logic [VALUE_BITS-1:0] mag, logic neg);
    logic [VALUE_BITS-1:0] r;
    if (neg) begin
      r = VALUE_BITS'(0) - mag;
    end else begin
      r = mag[VALUE_BITS-1] ? VALUE_BITS'(MAG_LIM - 1'b1) : mag;
    end
    return r;
  endfunction

  // One word byte: decimal and hex interpretations run side by side
  function automatic word_st_t word_step(word_st_t s, logic [7:0] c, logic [7:0] first);
    word_st_t   n;
    logic [4:0] hv;
    n  = s;
    hv = hex_digit(c);
    if ((s.len == '0) && (c == CH_MINUS)) begin
      n.flags.neg = 1'b1;
    end else if (is_dec_digit(c)) begin
      n.flags.ddig = 1'b1;
      n.dec = acc10(s.dec, c[3:0]);
    end else begin
      n.flags.dbad = 1'b1;
    end
    if ((s.len == COL_W'(1)) && (first == CH_ZERO) && ((c == CH_LO_X) || (c == CH_UP_X))) begin
      n.flags.hex = 1'b1;
    end else if ((s.len >= COL_W'(2)) && s.flags.hex) begin
      if ((s.len == COL_W'(2)) && (c == CH_MINUS)) begin
        n.flags.hneg = 1'b1;
      end else if (hv[4]) begin
        n.flags.hdig = 1'b1;
        n.hex = acc16(s.hex, hv[3:0]);
      end else begin
        n.flags.hbad = 1'b1;
      end
    end
    n.len = sat_col(s.len);
    return n;
  endfunction

  // ---------------------------------------------------------------- state
  lex_mode_t                  mode_r, mode_nxt;
  logic                       qsingle_r, qsingle_nxt;
  logic [VALUE_BITS-1:0]      dec_r, dec_nxt;
  logic [VALUE_BITS-1:0]      hex_r, hex_nxt;
  word_flags_t                flags_r, flags_nxt;
  logic [7:0]                 first_r, first_nxt;
  logic [COL_W-1:0]           tok_col_r, tok_col_nxt;
  logic [COL_W-1:0]           tok_len_r, tok_len_nxt;
  logic [LINE_COUNT_BITS-1:0] line_r, line_nxt;
  logic [COL_W-1:0]           col_r, col_nxt;
  logic [ERR_W-1:0]           err_r, err_nxt;

  rec_t                       q_r [Q_DEPTH];
  logic [PTR_W-1:0]           head_r, tail_r;
  logic [CNT_W-1:0]           cnt_r;

  logic                       in_xfer, out_xfer;
  logic [7:0]                 c;
  word_st_t                   cur_ws, cont_ws, fresh_ws;

  // closing results for the open token
  kind_t                      wc_kind, qc_kind;
  logic [VALUE_BITS-1:0]      wc_val, qc_val;
  logic [COL_W-1:0]           wc_len, qc_len;
  logic                       wc_bump, qc_bump;

  // records of this item: A closes a token, B comes from the byte itself
  logic                       a_vld, b_vld, a_bump, b_bump, do_idle;
  rec_t                       rec_a, rec_b, rec_first;
  logic [ERR_W-1:0]           errs_a, errs_b;
  logic [PTR_W-1:0]           tail_inc;
  logic [CNT_W-1:0]           push_n;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign c        = in_text_byte;

  assign cur_ws   = '{flags: flags_r, dec: dec_r, hex: hex_r, len: tok_len_r};
  assign cont_ws  = word_step(cur_ws, c, first_r);
  assign fresh_ws = word_step('0, c, c);

  // Word close: hex form wins over decimal, else identifier
  always_comb begin
    wc_kind = KIND_IDENT;
    wc_val  = '0;
    wc_len  = '0;
    wc_bump = 1'b0;
    if (flags_r.hex) begin
      if (!flags_r.hbad && (flags_r.hdig || !flags_r.hneg)) begin
        wc_kind = KIND_INTEGER;
        wc_val  = signed_val(hex_r, flags_r.hneg);
      end else begin
        wc_kind = KIND_BADHEX;
        wc_bump = 1'b1;
      end
    end else if (!flags_r.dbad && flags_r.ddig) begin
      wc_kind = KIND_INTEGER;
      wc_val  = signed_val(dec_r, flags_r.neg);
    end else begin
      wc_len = tok_len_r;
    end
  end

  // Quote close: a character literal must hold exactly one byte
  always_comb begin
    qc_kind = KIND_STRING;
    qc_val  = '0;
    qc_len  = '0;
    qc_bump = 1'b0;
    if (qsingle_r) begin
      if (tok_len_r == COL_W'(1)) begin
        qc_kind = KIND_INTEGER;
        qc_val  = VALUE_BITS'(first_r);
      end else begin
        qc_kind = KIND_BADCHAR;
        qc_bump = 1'b1;
      end
    end else begin
      qc_len = tok_len_r;
    end
  end

  // Next state and the records of this item
  always_comb begin
    mode_nxt    = mode_r;
    qsingle_nxt = qsingle_r;
    dec_nxt     = dec_r;
    hex_nxt     = hex_r;
    flags_nxt   = flags_r;
    first_nxt   = first_r;
    tok_col_nxt = tok_col_r;
    tok_len_nxt = tok_len_r;
    line_nxt    = line_r;
    col_nxt     = col_r;
    a_vld       = 1'b0;
    b_vld       = 1'b0;
    a_bump      = 1'b0;
    b_bump      = 1'b0;
    do_idle     = 1'b0;
    rec_a       = '0;
    rec_b       = '0;
    rec_a.kind  = KIND_IDENT;
    rec_b.kind  = KIND_IDENT;

    // the pending token is closed by a line feed, a delimiter or the end
    if (mode_r == MODE_WORD) begin
      rec_a.kind  = wc_kind;
      rec_a.value = wc_val;
      rec_a.len   = wc_len;
      a_bump      = wc_bump;
    end else begin
      rec_a.kind  = qc_kind;
      rec_a.value = qc_val;
      rec_a.len   = qc_len;
      a_bump      = qc_bump;
    end
    rec_a.col = tok_col_r;

    if (in_end_of_input) begin
      a_vld       = (mode_r == MODE_WORD) || (mode_r == MODE_QUOTE);
      b_vld       = 1'b1;
      rec_b.kind  = KIND_END;
      rec_b.col   = col_r;
      mode_nxt    = MODE_IDLE;
      qsingle_nxt = 1'b0;
      dec_nxt     = '0;
      hex_nxt     = '0;
      flags_nxt   = '0;
      first_nxt   = '0;
      tok_col_nxt = '0;
      tok_len_nxt = '0;
      line_nxt    = LINE_COUNT_BITS'(1);
      col_nxt     = '0;
    end else if (c == CH_CR) begin
      // dropped without effect
    end else if (c == CH_LF) begin
      a_vld    = (mode_r == MODE_WORD) || (mode_r == MODE_QUOTE);
      mode_nxt = MODE_IDLE;
      line_nxt = (line_r != LINE_MAX) ? LINE_COUNT_BITS'(line_r + 1'b1) : line_r;
      col_nxt  = '0;
    end else begin
      col_nxt = sat_col(col_r);
      unique case (mode_r)
        MODE_QUOTE: begin
          if (c == (qsingle_r ? CH_SQUOTE : CH_DQUOTE)) begin
            a_vld    = 1'b1;
            mode_nxt = MODE_IDLE;
          end else begin
            if (tok_len_r == '0) begin
              first_nxt = c;
            end
            tok_len_nxt = sat_col(tok_len_r);
          end
        end
        MODE_WORD: begin
          if (is_word_byte(c)) begin
            flags_nxt   = cont_ws.flags;
            dec_nxt     = cont_ws.dec;
            hex_nxt     = cont_ws.hex;
            tok_len_nxt = cont_ws.len;
          end else begin
            a_vld    = 1'b1;
            mode_nxt = MODE_IDLE;
            do_idle  = 1'b1;
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
          do_idle  = 1'b1;
        end
      endcase
    end

    // byte seen between tokens
    if (do_idle) begin
      rec_b.col = col_r;
      if (c == CH_LBRACE) begin
        b_vld      = 1'b1;
        rec_b.kind = KIND_OPEN;
      end else if (c == CH_RBRACE) begin
        b_vld      = 1'b1;
        rec_b.kind = KIND_CLOSE;
      end else if (c == CH_SEMI) begin
        b_vld      = 1'b1;
        rec_b.kind = KIND_SEMICOLON;
      end else if ((c == CH_SPACE) || (c == CH_TAB)) begin
        // whitespace
      end else if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
        mode_nxt    = MODE_QUOTE;
        qsingle_nxt = (c == CH_SQUOTE);
        tok_len_nxt = '0;
        first_nxt   = '0;
        tok_col_nxt = sat_col(col_r);
      end else if (is_word_byte(c)) begin
        mode_nxt    = MODE_WORD;
        flags_nxt   = fresh_ws.flags;
        dec_nxt     = fresh_ws.dec;
        hex_nxt     = fresh_ws.hex;
        tok_len_nxt = fresh_ws.len;
        tok_col_nxt = col_r;
        first_nxt   = c;
      end else begin
        b_vld      = 1'b1;
        b_bump     = 1'b1;
        rec_b.kind = KIND_UNEXPECTED;
      end
    end

    // error counts as seen after each record
    errs_a      = (a_vld && a_bump) ? sat_err(err_r) : err_r;
    errs_b      = (b_vld && b_bump) ? sat_err(errs_a) : errs_a;
    err_nxt     = in_end_of_input ? '0 : errs_b;
    rec_a.errs  = errs_a;
    rec_b.errs  = errs_b;
    rec_a.line  = line_r;
    rec_b.line  = line_r;
    rec_a.last  = !b_vld;
    rec_b.last  = 1'b1;
  end

  assign rec_first = a_vld ? rec_a : rec_b;
  assign tail_inc  = PTR_W'(tail_r + 1'b1);
  assign push_n    = in_xfer ? (CNT_W'(a_vld) + CNT_W'(b_vld)) : '0;

  // Lexer state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      qsingle_r <= 1'b0;
      dec_r     <= '0;
      hex_r     <= '0;
      flags_r   <= '0;
      first_r   <= '0;
      tok_col_r <= '0;
      tok_len_r <= '0;
      line_r    <= LINE_COUNT_BITS'(1);
      col_r     <= '0;
      err_r     <= '0;
    end else if (in_xfer) begin
      mode_r    <= mode_nxt;
      qsingle_r <= qsingle_nxt;
      dec_r     <= dec_nxt;
      hex_r     <= hex_nxt;
      flags_r   <= flags_nxt;
      first_r   <= first_nxt;
      tok_col_r <= tok_col_nxt;
      tok_len_r <= tok_len_nxt;
      line_r    <= line_nxt;
      col_r     <= col_nxt;
      err_r     <= err_nxt;
    end
  end

  // Result queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      tail_r <= PTR_W'(tail_r + push_n);
      if (out_xfer) begin
        head_r <= PTR_W'(head_r + 1'b1);
      end
      cnt_r <= CNT_W'(cnt_r + push_n - CNT_W'(out_xfer));
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (in_xfer && (a_vld || b_vld)) begin
      q_r[tail_r] <= rec_first;
    end
    if (in_xfer && a_vld && b_vld) begin
      q_r[tail_inc] <= rec_b;
    end
  end

  // room for the two records one item can give
  assign in_stall        = (cnt_r > CNT_W'(Q_DEPTH - 2));
  assign out_valid       = (cnt_r != '0);
  assign out_kind        = q_r[head_r].kind;
  assign out_int_value   = $signed(q_r[head_r].value);
  assign out_line_number = q_r[head_r].line;
  assign out_start_column = q_r[head_r].col;
  assign out_text_length = q_r[head_r].len;
  assign out_error_count = q_r[head_r].errs;
  assign out_last_of_run = q_r[head_r].last;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(Q_DEPTH))
    else $error("result queue over-filled");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_end_of_input) |=>
      (mode_r == MODE_IDLE) && (line_r == LINE_COUNT_BITS'(1)) && (err_r == '0))
    else $error("end of input did not restore lexer state");

  a_err_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_end_of_input) |=> (err_r >= $past(err_r)))
    else $error("error count went down within a file");

  a_word_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_WORD) |-> (tok_len_r != '0))
    else $error("open word with zero length");
`endif

endmodule

// ===== test/data_file_tokenizer_top_tb.sv =====
// Self-checking testbench for the data file tokenizer: byte stimulus, token prediction, checks.
module data_file_tokenizer_top_tb;
  import dft_pkg::*;

  localparam int          WATCH_LIMIT = 1000;
  localparam logic [11:0] COL_MAX     = 12'hFFF;
  localparam logic [19:0] LINE_MAX    = 20'hFFFFF;
  localparam logic [63:0] MAG_LIM     = 64'h8000_0000;

  // One token record as it leaves the block
  typedef struct {
    kind_t       kind;
    logic [31:0] value;
    logic [19:0] line;
    logic [11:0] col;
    logic [11:0] len;
    logic [15:0] errs;
    logic        last;
  } token_rec_t;

  // Lexer copy and the queue of token records still owed by the block
  class token_tracker;
    lex_mode_t    mode;
    bit           quote_single;
    logic [63:0]  dec_mag, hex_mag;
    word_flags_t  flags;
    logic [7:0]   first_byte;
    logic [11:0]  tok_col, tok_len, col_no;
    logic [19:0]  line_no;
    logic [15:0]  err_cnt;
    token_rec_t   awaited_tokens[$];
    int unsigned  failures;

    function new();
      failures = 0;
      clear();
    endfunction

    function void clear();
      mode = MODE_IDLE;
      quote_single = 1'b0;
      dec_mag = '0;
      hex_mag = '0;
      flags = '0;
      first_byte = '0;
      tok_col = '0;
      tok_len = '0;
      line_no = 20'd1;
      col_no = '0;
      err_cnt = '0;
    endfunction

    task report(string what);
      failures++;
      $display("mismatch: %s", what);
    endtask

    function logic [11:0] bump_col(logic [11:0] v);
      return (v < COL_MAX) ? v + 12'd1 : COL_MAX;
    endfunction

    function void bump_err();
      if (err_cnt != 16'hFFFF) err_cnt++;
    endfunction

    function bit dec_char(logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function bit is_word(logic [7:0] c);
      return dec_char(c) || ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
             ((c >= CH_UP_A) && (c <= CH_UP_Z)) || (c == CH_MINUS) || (c == CH_UNDER);
    endfunction

    function int hex_of(logic [7:0] c);
      if (dec_char(c)) return int'(c) - int'(CH_ZERO);
      if ((c >= CH_LO_A) && (c <= CH_LO_F)) return int'(c) - int'(CH_LO_A) + 10;
      if ((c >= CH_UP_A) && (c <= CH_UP_F)) return int'(c) - int'(CH_UP_A) + 10;
      return -1;
    endfunction

    // Magnitude accumulate, pinned at 2^31 once it would pass it
    function logic [63:0] add_digit(logic [63:0] mag, logic [63:0] base, logic [63:0] d);
      if (mag > (MAG_LIM - d) / base) return MAG_LIM;
      return mag * base + d;
    endfunction

    function logic [31:0] to_value(logic [63:0] mag, logic neg);
      logic [63:0] negated;
      negated = 64'd0 - mag;
      if (neg) return negated[31:0];
      return (mag >= MAG_LIM) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function void emit(kind_t k, logic [31:0] v, logic [11:0] c, logic [11:0] n);
      token_rec_t r;
      r.kind  = k;
      r.value = v;
      r.line  = line_no;
      r.col   = c;
      r.len   = n;
      r.errs  = err_cnt;
      r.last  = 1'b0;
      awaited_tokens.insert(awaited_tokens.size(), r);
    endfunction

    function void word_byte(logic [7:0] c);
      logic [11:0] p;
      int h;
      p = tok_len;
      if ((p == 0) && (c == CH_MINUS)) flags.neg = 1'b1;
      else if (dec_char(c)) begin
        flags.ddig = 1'b1;
        dec_mag = add_digit(dec_mag, 64'd10, 64'(c) - 64'(CH_ZERO));
      end else flags.dbad = 1'b1;
      // hex body starts at the third byte
      if ((p == 1) && (first_byte == CH_ZERO) && ((c == CH_LO_X) || (c == CH_UP_X))) begin
        flags.hex = 1'b1;
      end else if ((p >= 2) && flags.hex) begin
        h = hex_of(c);
        if ((p == 2) && (c == CH_MINUS)) flags.hneg = 1'b1;
        else if (h >= 0) begin
          flags.hdig = 1'b1;
          hex_mag = add_digit(hex_mag, 64'd16, 64'(h));
        end else flags.hbad = 1'b1;
      end
      tok_len = bump_col(tok_len);
    endfunction

    function void close_word();
      mode = MODE_IDLE;
      if (flags.hex) begin
        if (!flags.hbad && (flags.hdig || !flags.hneg)) begin
          emit(KIND_INTEGER, to_value(hex_mag, flags.hneg), tok_col, '0);
        end else begin
          bump_err();
          emit(KIND_BADHEX, '0, tok_col, '0);
        end
      end else if (!flags.dbad && flags.ddig) begin
        emit(KIND_INTEGER, to_value(dec_mag, flags.neg), tok_col, '0);
      end else begin
        emit(KIND_IDENT, '0, tok_col, tok_len);
      end
    endfunction

    function void close_quote();
      mode = MODE_IDLE;
      if (quote_single) begin
        if (tok_len == 12'd1) emit(KIND_INTEGER, {24'd0, first_byte}, tok_col, '0);
        else begin
          bump_err();
          emit(KIND_BADCHAR, '0, tok_col, '0);
        end
      end else begin
        emit(KIND_STRING, '0, tok_col, tok_len);
      end
    endfunction

    function void close_pending();
      if (mode == MODE_WORD) close_word();
      else if (mode == MODE_QUOTE) close_quote();
      mode = MODE_IDLE;
    endfunction

    // A byte seen between tokens
    function void idle_byte(logic [7:0] c, logic [11:0] col);
      if ((c == CH_SPACE) || (c == CH_TAB)) return;
      if (c == CH_LBRACE) emit(KIND_OPEN, '0, col, '0);
      else if (c == CH_RBRACE) emit(KIND_CLOSE, '0, col, '0);
      else if (c == CH_SEMI) emit(KIND_SEMICOLON, '0, col, '0);
      else if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
        mode = MODE_QUOTE;
        quote_single = (c == CH_SQUOTE);
        tok_len = '0;
        first_byte = '0;
        tok_col = bump_col(col);
      end else if (is_word(c)) begin
        mode = MODE_WORD;
        flags = '0;
        dec_mag = '0;
        hex_mag = '0;
        tok_len = '0;
        tok_col = col;
        first_byte = c;
        word_byte(c);
      end else begin
        bump_err();
        emit(KIND_UNEXPECTED, '0, col, '0);
      end
    endfunction

    // Predict the records caused by one accepted input transfer
    function void lex_byte(logic [7:0] c, logic eoi);
      int before_n;
      logic [11:0] col;
      before_n = awaited_tokens.size();
      if (eoi) begin
        close_pending();
        emit(KIND_END, '0, col_no, '0);
        awaited_tokens[awaited_tokens.size()-1].last = 1'b1;
        clear();
        return;
      end
      if (c == CH_CR) return;
      if (c == CH_LF) begin
        close_pending();
        if (line_no != LINE_MAX) line_no++;
        col_no = '0;
      end else begin
        col = col_no;
        if (mode == MODE_QUOTE) begin
          if (c == (quote_single ? CH_SQUOTE : CH_DQUOTE)) close_quote();
          else begin
            if (tok_len == 0) first_byte = c;
            tok_len = bump_col(tok_len);
          end
        end else if (mode == MODE_WORD) begin
          if (is_word(c)) word_byte(c);
          else begin
            close_word();
            idle_byte(c, col);
          end
        end else begin
          idle_byte(c, col);
        end
        col_no = bump_col(col_no);
      end
      if (awaited_tokens.size() > before_n) awaited_tokens[awaited_tokens.size()-1].last = 1'b1;
    endfunction

    // Compare a record from the block with the oldest one owed
    task check_token(token_rec_t got);
      token_rec_t want;
      string at;
      if (awaited_tokens.size() == 0) begin
        report($sformatf("record kind %0d line %0d with nothing owed", got.kind, got.line));
        return;
      end
      want = awaited_tokens.pop_front();
      at = $sformatf("line %0d col %0d kind %0d", want.line, want.col, want.kind);
      if (got.kind !== want.kind) report($sformatf("%s: kind %0d", at, got.kind));
      if (got.value !== want.value) report($sformatf("%s: value %0h want %0h", at, got.value, want.value));
      if (got.line !== want.line) report($sformatf("%s: line %0d", at, got.line));
      if (got.col !== want.col) report($sformatf("%s: column %0d", at, got.col));
      if (got.len !== want.len) report($sformatf("%s: length %0d want %0d", at, got.len, want.len));
      if (got.errs !== want.errs) report($sformatf("%s: errors %0d want %0d", at, got.errs, want.errs));
      if (got.last !== want.last) report($sformatf("%s: last %0b", at, got.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_stall, in_end_of_input;
  logic [7:0] in_text_byte;
  logic out_valid, out_stall, out_last_of_run;
  kind_t out_kind;
  logic signed [31:0] out_int_value;
  logic [19:0] out_line_number;
  logic [11:0] out_start_column, out_text_length;
  logic [15:0] out_error_count;

  token_tracker tracker;
  token_rec_t   seen;
  bit           tx_calm, rx_calm, hold_req;
  int           hold_left;
  int           idle_cycles;
  int unsigned  items_sent;
  string        word_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_";
  string        hex_set  = "0123456789abcdefABCDEF";

  data_file_tokenizer_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .in_end_of_input  (in_end_of_input),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_int_value    (out_int_value),
    .out_line_number  (out_line_number),
    .out_start_column (out_start_column),
    .out_text_length  (out_text_length),
    .out_error_count  (out_error_count),
    .out_last_of_run  (out_last_of_run)
  );

  always #1 clk = ~clk;

  // Transfer monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) tracker.lex_byte(in_text_byte, in_end_of_input);
      if (out_valid && !out_stall) begin
        seen.kind  = out_kind;
        seen.value = out_int_value;
        seen.line  = out_line_number;
        seen.col   = out_start_column;
        seen.len   = out_text_length;
        seen.errs  = out_error_count;
        seen.last  = out_last_of_run;
        tracker.check_token(seen);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 79;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !rx_calm && ($urandom_range(99) < 32);
      end
    end
  end

  // One input transfer; returns at the falling edge after acceptance
  task automatic put_byte(logic [7:0] b, logic eoi);
    while (!tx_calm && ($urandom_range(99) < 32)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= b;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i], 1'b0);
  endtask

  task automatic send_end();
    put_byte(8'($urandom_range(255)), 1'b1);
  endtask

  // Mostly well-formed tokens with random content, some noise
  task automatic send_random_token();
    int pick, n;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 12) begin
      case ($urandom_range(2))
        0: put_byte(CH_LBRACE, 1'b0);
        1: put_byte(CH_RBRACE, 1'b0);
        default: put_byte(CH_SEMI, 1'b0);
      endcase
    end else if (pick < 27) begin
      // decimal, sometimes right at the edges of the value range
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0: send_text("2147483647");
          1: send_text("2147483648");
          2: send_text("-2147483648");
          default: send_text("-2147483649");
        endcase
      end else begin
        if ($urandom_range(3) == 0) put_byte(CH_MINUS, 1'b0);
        n = ($urandom_range(9) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 4);
        repeat (n) put_byte(8'(CH_ZERO + $urandom_range(9)), 1'b0);
      end
    end else if (pick < 40) begin
      put_byte(CH_ZERO, 1'b0);
      put_byte($urandom_range(1) ? CH_LO_X : CH_UP_X, 1'b0);
      if ($urandom_range(4) == 0) put_byte(CH_MINUS, 1'b0);
      n = ($urandom_range(4) == 0) ? $urandom_range(8, 10) : $urandom_range(0, 3);
      repeat (n) put_byte(hex_set[$urandom_range(hex_set.len() - 1)], 1'b0);
      // stray word byte, often not a hex digit
      if ($urandom_range(7) == 0) put_byte(word_set[$urandom_range(word_set.len() - 1)], 1'b0);
    end else if (pick < 55) begin
      n = ($urandom_range(19) == 0) ? 40 : $urandom_range(1, 6);
      repeat (n) put_byte(word_set[$urandom_range(word_set.len() - 1)], 1'b0);
    end else if (pick < 65) begin
      put_byte(CH_DQUOTE, 1'b0);
      repeat ($urandom_range(0, 6)) begin
        b = 8'($urandom_range(32, 255));
        put_byte((b == CH_DQUOTE) ? CH_SQUOTE : b, 1'b0);
      end
      if ($urandom_range(7) != 0) put_byte(CH_DQUOTE, 1'b0);
    end else if (pick < 73) begin
      put_byte(CH_SQUOTE, 1'b0);
      n = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 0 : 2) : 1;
      repeat (n) begin
        b = 8'($urandom_range(32, 126));
        put_byte((b == CH_SQUOTE) ? CH_DQUOTE : b, 1'b0);
      end
      put_byte(CH_SQUOTE, 1'b0);
    end else if (pick < 88) begin
      case ($urandom_range(3))
        0: put_byte(CH_SPACE, 1'b0);
        1: put_byte(CH_TAB, 1'b0);
        2: put_byte(CH_LF, 1'b0);
        default: put_byte(CH_CR, 1'b0);
      endcase
    end else begin
      put_byte(8'($urandom_range(255)), 1'b0);
    end
    if ((pick >= 12) && (pick < 55) && $urandom_range(1)) put_byte(CH_SPACE, 1'b0);
  endtask

  // Stimulus
  initial begin
    bit pressed;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_text_byte = '0;
    in_end_of_input = 1'b0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    hold_req = 1'b0;
    pressed = 1'b0;
    idle_cycles = 0;
    items_sent = 0;
    tracker = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: negative hex, word closed by a brace, lone minus, character literal,
    // high byte, quote cut by a line feed, dropped CR, empty signed hex, tab, end
    send_text("{0x-F}-;'z'");
    put_byte(8'hFF, 1'b0);
    send_text("\"q");
    put_byte(CH_CR, 1'b0);
    put_byte(CH_LF, 1'b0);
    send_text("0x-;9");
    put_byte(CH_TAB, 1'b0);
    send_end();

    // random files
    while (items_sent < 430) begin
      if ((items_sent >= 150) && !pressed) begin
        hold_req = 1'b1;
        pressed = 1'b1;
      end
      tx_calm = (items_sent >= 300) && (items_sent < 380);
      rx_calm = tx_calm;
      send_random_token();
      if ($urandom_range(99) < 3) send_end();
    end
    send_end();
    in_valid <= 1'b0;

    while (tracker.awaited_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.failures == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
